// ===== rtl/char_lcd_expander_sequencer_macros.svh =====
// ----------------------------------------------------------------------------
// Character LCD expander sequencer: assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_EXPANDER_SEQUENCER_MACROS_SVH
`define CHAR_LCD_EXPANDER_SEQUENCER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define CLCD_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define CLCD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/clcd_pkg.sv =====
// ----------------------------------------------------------------------------
// Character LCD expander sequencer package
// Types, command codes, register indexes and the init byte table.
// ----------------------------------------------------------------------------
package clcd_pkg;

	typedef enum logic [2:0] {
		CMD_INSTR  = 3'd0,
		CMD_CHAR   = 3'd1,
		CMD_CURSOR = 3'd2,
		CMD_GLYPH  = 3'd3,
		CMD_INIT   = 3'd4
	} clcd_cmd_t;

	typedef enum logic [1:0] {
		REG_BACKLIGHT  = 2'd0,
		REG_ENABLE     = 2'd1,
		REG_DATA_SEL   = 2'd2,
		REG_CMD_SEL    = 2'd3
	} clcd_reg_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_RUN  = 1'b1
	} clcd_state_t;

	// Write phases within one nibble.
	typedef enum logic [1:0] {
		PH_SETUP  = 2'd0,
		PH_STROBE = 2'd1,
		PH_HOLD   = 2'd2
	} clcd_phase_t;

	typedef struct packed {
		logic load;     // latch the input word and restart the counters
		logic advance;  // produce the next expander word
	} clcd_ctrl_t;

	typedef struct packed {
		logic has_output; // the offered input word causes at least one write
		logic final_word; // the word about to be produced is the last one
		logic out_valid;  // output register holds a word
	} clcd_stat_t;

	localparam logic [7:0] ROW1_ADDR   = 8'h80;
	localparam logic [7:0] ROW2_ADDR   = 8'hC0;
	localparam logic [7:0] CGRAM_BASE  = 8'h40;
	localparam logic [2:0] INIT_LAST   = 3'd5;

	localparam logic [7:0] RST_BACKLIGHT = 8'h08;
	localparam logic [7:0] RST_ENABLE    = 8'h04;
	localparam logic [7:0] RST_DATA_SEL  = 8'h01;
	localparam logic [7:0] RST_CMD_SEL   = 8'h00;

	function automatic logic [7:0] init_byte(input logic [2:0] idx);
		logic [7:0] b;
		case (idx)
			3'd0: b = 8'h33;
			3'd1: b = 8'h32;
			3'd2: b = 8'h06;
			3'd3: b = 8'h0C;
			3'd4: b = 8'h28;
			3'd5: b = 8'h01;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

// ===== rtl/char_lcd_expander_sequencer.sv =====
// ----------------------------------------------------------------------------
// Character LCD expander sequencer (top level)
// Expands LCD operations into port expander writes for a 4-bit HD44780 bus.
// ----------------------------------------------------------------------------
// Each accepted operation word becomes a stream of expander bytes, one output
// word per clock while the output side does not stall. A byte goes out high
// nibble first; each nibble is three writes (setup, enable high, enable low),
// so instruction, character, cursor and glyph operations give six writes and
// init gives thirty-six. An operation is first accepted, then its writes follow.
// The write pace is set by the single output register, which the sequencer
// refills once per cycle while the output side does not stall. The next
// operation is accepted in the cycle after the final write is loaded, so the
// last word may still be waiting while a new operation comes in. Glyph select
// with an index of eight or more, and unused command codes, are accepted and
// produce nothing. The final write of an operation carries last. Mask
// registers are sampled live and must only be written while the block is idle.
// ----------------------------------------------------------------------------
module char_lcd_expander_sequencer
	import clcd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	// Configuration write port.
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	// Operation channel.
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] command,
	input  logic [7:0] value,
	input  logic [1:0] row,
	input  logic [7:0] column,
	input  logic [3:0] glyph_index,
	// Expander word channel.
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] expander_byte,
	output logic       last
);

	`include "char_lcd_expander_sequencer_macros.svh"

	clcd_ctrl_t ctrl;
	clcd_stat_t stat;

	// The controller decides when to take an operation and when to step.
	clcd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_stall (out_stall),
		.stat      (stat),
		.ctrl      (ctrl)
	);

	// The datapath holds the masks, the current byte and the output register.
	clcd_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.command       (command),
		.value         (value),
		.row           (row),
		.column        (column),
		.glyph_index   (glyph_index),
		.out_stall     (out_stall),
		.ctrl          (ctrl),
		.stat          (stat),
		.expander_byte (expander_byte),
		.last          (last)
	);

	assign out_valid = stat.out_valid;

	// An operation that writes something blocks the input until its final word is loaded.
	`CLCD_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall && stat.has_output, in_stall, "input not held off after accepting a writing operation")
	// The final word of an operation releases the input on the next cycle.
	`CLCD_ASSERT_NEXT(a_idle_after_final, ctrl.advance && stat.final_word, !in_stall && out_valid && last, "final word did not end the sequence")
	// No word is produced while the input side is open.
	`CLCD_ASSERT_SAME(a_no_step_when_idle, !in_stall, !ctrl.advance, "word produced while idle")

endmodule

// ===== rtl/clcd_ctrl.sv =====
// ----------------------------------------------------------------------------
// Character LCD expander sequencer: controller
// Two-state machine that accepts an operation and paces the word stream.
// ----------------------------------------------------------------------------
module clcd_ctrl
	import clcd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       out_stall,
	input  clcd_stat_t stat,
	output clcd_ctrl_t ctrl
);

	clcd_state_t state_q;
	clcd_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		ctrl.load    = 1'b0;
		ctrl.advance = 1'b0;
		in_stall     = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall  = 1'b0;
				ctrl.load = in_valid;
				if (in_valid && stat.has_output) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				ctrl.advance = !stat.out_valid || !out_stall;
				if (ctrl.advance && stat.final_word) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/clcd_dp.sv =====
// ----------------------------------------------------------------------------
// Character LCD expander sequencer: datapath
// Mask registers, latched byte, nibble and phase counters, output register.
// ----------------------------------------------------------------------------
module clcd_dp
	import clcd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic [2:0] command,
	input  logic [7:0] value,
	input  logic [1:0] row,
	input  logic [7:0] column,
	input  logic [3:0] glyph_index,
	input  logic       out_stall,
	input  clcd_ctrl_t ctrl,
	output clcd_stat_t stat,
	output logic [7:0] expander_byte,
	output logic       last
);

	logic [7:0]  backlight_q;
	logic [7:0]  enable_q;
	logic [7:0]  data_sel_q;
	logic [7:0]  cmd_sel_q;

	logic [7:0]  byte_q;
	logic        use_data_q;
	logic        init_q;
	logic [2:0]  byte_idx_q;
	logic        low_nib_q;
	clcd_phase_t phase_q;

	logic [7:0]  out_byte_q;
	logic        out_last_q;
	logic        out_valid_q;

	logic [7:0]  load_byte;
	logic        has_output;
	logic [7:0]  cur_byte;
	logic [3:0]  nibble;
	logic [7:0]  pattern;
	logic [7:0]  word;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			backlight_q <= RST_BACKLIGHT;
			enable_q    <= RST_ENABLE;
			data_sel_q  <= RST_DATA_SEL;
			cmd_sel_q   <= RST_CMD_SEL;
		end else if (cfg_we) begin
			case (clcd_reg_t'(cfg_index))
				REG_BACKLIGHT: backlight_q <= cfg_data;
				REG_ENABLE:    enable_q    <= cfg_data;
				REG_DATA_SEL:  data_sel_q  <= cfg_data;
				REG_CMD_SEL:   cmd_sel_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Byte for a single-byte operation, and whether the operation writes at all.
	always_comb begin
		load_byte  = value;
		has_output = 1'b1;
		case (clcd_cmd_t'(command))
			CMD_INSTR, CMD_CHAR: load_byte = value;
			CMD_CURSOR: begin
				if (row == 2'd1) begin
					load_byte = ROW1_ADDR | {4'h0, column[3:0]};
				end else if (row == 2'd2) begin
					load_byte = ROW2_ADDR | {4'h0, column[3:0]};
				end else begin
					load_byte = 8'h00;
				end
			end
			CMD_GLYPH: begin
				load_byte  = CGRAM_BASE | {2'b00, glyph_index[2:0], 3'b000};
				has_output = !glyph_index[3];
			end
			CMD_INIT: load_byte = 8'h00;
			default: has_output = 1'b0;
		endcase
	end

	always_comb begin
		cur_byte = init_q ? init_byte(byte_idx_q) : byte_q;
		nibble   = low_nib_q ? cur_byte[3:0] : cur_byte[7:4];
		pattern  = {nibble, 4'h0} | backlight_q | (use_data_q ? data_sel_q : cmd_sel_q);
		case (phase_q)
			PH_SETUP:  word = pattern;
			PH_STROBE: word = pattern | enable_q;
			PH_HOLD:   word = pattern & ~enable_q;
			default:   word = pattern;
		endcase
		stat.has_output = has_output;
		stat.final_word = (phase_q == PH_HOLD) && low_nib_q
			&& (!init_q || (byte_idx_q == INIT_LAST));
		stat.out_valid  = out_valid_q;
	end

	// Sequence counters: phase inside a nibble, nibble, byte of the init run.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q     <= 1'b0;
			use_data_q <= 1'b0;
			byte_idx_q <= 3'd0;
			low_nib_q  <= 1'b0;
			phase_q    <= PH_SETUP;
		end else if (ctrl.load) begin
			init_q     <= clcd_cmd_t'(command) == CMD_INIT;
			use_data_q <= clcd_cmd_t'(command) == CMD_CHAR;
			byte_idx_q <= 3'd0;
			low_nib_q  <= 1'b0;
			phase_q    <= PH_SETUP;
		end else if (ctrl.advance) begin
			case (phase_q)
				PH_SETUP:  phase_q <= PH_STROBE;
				PH_STROBE: phase_q <= PH_HOLD;
				default: begin
					phase_q   <= PH_SETUP;
					low_nib_q <= !low_nib_q;
					if (low_nib_q) begin
						byte_idx_q <= byte_idx_q + 3'd1;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			byte_q <= load_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.advance) begin
			out_byte_q <= word;
			out_last_q <= stat.final_word;
		end
	end

	assign expander_byte = out_byte_q;
	assign last          = out_last_q;

endmodule

// ===== tb/sv/char_lcd_expander_sequencer_test.sv =====
// ----------------------------------------------------------------------------
// Character LCD expander sequencer testbench
// Drives LCD operation words into the sequencer under random handshake gaps
// and compares every expander word against a local expansion of the operation
// or typed words. The masks are changed between phases while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module char_lcd_expander_sequencer_test
	import clcd_pkg::*;
();

	localparam int CLK_HALF_NS      = 6;
	localparam int RESET_CYCLES     = 10;
	// Init is the longest operation at 36 words, so a short margin past that
	// covers any word still in flight before the masks change.
	localparam int SETTLE_CYCLES    = 40;
	localparam int LONG_HOLD_CYCLES = 200;
	localparam int CYCLE_LIMIT      = 200000;
	localparam int PHASES           = 6;
	localparam int OPS_PER_PHASE    = 36;
	localparam int N_DIRECTED       = 22;

	// Command codes the block does not define; they must be dropped silently.
	localparam logic [2:0] CMD_SPARE_A = 3'd5;
	localparam logic [2:0] CMD_SPARE_B = 3'd6;
	localparam logic [2:0] CMD_SPARE_C = 3'd7;

	// Rows that select a DDRAM line; any other row gives address zero.
	localparam logic [1:0] ROW_FIRST  = 2'd1;
	localparam logic [1:0] ROW_SECOND = 2'd2;

	// Power-up instruction bytes, first byte in the top octet.
	localparam logic [47:0] POWER_UP_BYTES = 48'h33_32_06_0C_28_01;

	typedef struct packed {
		logic [2:0] command;
		logic [7:0] value;
		logic [1:0] row;
		logic [7:0] column;
		logic [3:0] glyph_index;
	} lcd_op_t;

	typedef struct packed {
		logic [7:0] expander_byte;
		logic       last;
	} lcd_write_t;

	// How a directed row gets its expected words: from the local expansion,
	// from the six words typed into the row, or none at all.
	typedef enum logic [1:0] {
		CHK_MODEL,
		CHK_TYPED,
		CHK_SILENT
	} row_check_t;

	typedef struct packed {
		lcd_op_t    op;
		row_check_t check;
		logic [47:0] words;
	} directed_row_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_index;
	logic [7:0] cfg_data;
	logic       in_valid;
	logic       in_stall;
	logic [2:0] command;
	logic [7:0] value;
	logic [1:0] row;
	logic [7:0] column;
	logic [3:0] glyph_index;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] expander_byte;
	logic       last;

	// Shadow copies of the mask registers, updated as they are written.
	logic [7:0] backlight_bits;
	logic [7:0] enable_bits;
	logic [7:0] data_sel_bits;
	logic [7:0] cmd_sel_bits;

	lcd_write_t pending_writes[$];

	int  mismatches;
	int  words_checked;
	int  writes_predicted;
	int  ops_sent;
	int  cycle_count;
	int  rx_wait;
	bit  quiet;
	bit  long_hold_req;

	char_lcd_expander_sequencer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.value        (value),
		.row          (row),
		.column       (column),
		.glyph_index  (glyph_index),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.expander_byte(expander_byte),
		.last         (last)
	);

	// Directed words. The typed rows rely on the reset mask values
	// (backlight 0x08, enable 0x04, data select 0x01, command select 0x00).
	// Silent rows are the out-of-range glyph slots and the unused codes;
	// they sit between busy rows so they arrive while words are still queued.
	directed_row_t directed_ops [N_DIRECTED] = '{
		'{'{CMD_INSTR,  8'h00, 2'd0, 8'h00, 4'h0}, CHK_TYPED,  48'h08_0C_08_08_0C_08},
		'{'{CMD_CHAR,   8'hFF, 2'd3, 8'hFF, 4'hF}, CHK_TYPED,  48'hF9_FD_F9_F9_FD_F9},
		'{'{CMD_CURSOR, 8'h00, 2'd1, 8'hFF, 4'h0}, CHK_TYPED,  48'h88_8C_88_F8_FC_F8},
		'{'{CMD_GLYPH,  8'hFF, 2'd0, 8'h00, 4'h8}, CHK_SILENT, 48'h0},
		'{'{CMD_CURSOR, 8'hFF, 2'd2, 8'h00, 4'h0}, CHK_TYPED,  48'hC8_CC_C8_08_0C_08},
		'{'{CMD_GLYPH,  8'h00, 2'd0, 8'h00, 4'h7}, CHK_TYPED,  48'h78_7C_78_88_8C_88},
		'{'{CMD_CURSOR, 8'h00, 2'd0, 8'hFF, 4'h0}, CHK_TYPED,  48'h08_0C_08_08_0C_08},
		'{'{CMD_SPARE_A, 8'hFF, 2'd3, 8'hFF, 4'hF}, CHK_SILENT, 48'h0},
		'{'{CMD_INSTR,  8'hFF, 2'd0, 8'h00, 4'h0}, CHK_MODEL,  48'h0},
		'{'{CMD_GLYPH,  8'h00, 2'd3, 8'hFF, 4'hF}, CHK_SILENT, 48'h0},
		'{'{CMD_CHAR,   8'h00, 2'd0, 8'h00, 4'h0}, CHK_MODEL,  48'h0},
		'{'{CMD_SPARE_B, 8'h00, 2'd0, 8'h00, 4'h0}, CHK_SILENT, 48'h0},
		'{'{CMD_CHAR,   8'hA5, 2'd1, 8'h5A, 4'h9}, CHK_MODEL,  48'h0},
		'{'{CMD_INSTR,  8'h5A, 2'd2, 8'hA5, 4'h6}, CHK_MODEL,  48'h0},
		'{'{CMD_CURSOR, 8'h00, 2'd3, 8'h0A, 4'h0}, CHK_MODEL,  48'h0},
		'{'{CMD_SPARE_C, 8'h5A, 2'd1, 8'h3C, 4'h2}, CHK_SILENT, 48'h0},
		'{'{CMD_CURSOR, 8'h00, 2'd2, 8'hF7, 4'h0}, CHK_MODEL,  48'h0},
		'{'{CMD_CURSOR, 8'h00, 2'd1, 8'h30, 4'h0}, CHK_MODEL,  48'h0},
		'{'{CMD_GLYPH,  8'h00, 2'd0, 8'h00, 4'h0}, CHK_MODEL,  48'h0},
		'{'{CMD_GLYPH,  8'h00, 2'd0, 8'h00, 4'h3}, CHK_MODEL,  48'h0},
		'{'{CMD_INIT,   8'h00, 2'd0, 8'h00, 4'h0}, CHK_MODEL,  48'h0},
		'{'{CMD_INIT,   8'hFF, 2'd3, 8'hFF, 4'hF}, CHK_MODEL,  48'h0}
	};

	initial begin
		clk = 1'b0;
	end

	always #(CLK_HALF_NS) clk = ~clk;

	// Reset is applied once, held for a fixed number of cycles.
	initial begin
		arst_n = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Global watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		$display("%0t: mismatch: %s", $time, what);
		mismatches++;
	endtask

	task automatic push_write(input logic [7:0] pattern, input logic is_last);
		pending_writes.push_back('{expander_byte: pattern, last: is_last});
		writes_predicted++;
	endtask

	// One nibble is setup, enable high, then enable low. The low phase clears
	// every enable bit even where a select or backlight bit overlaps it.
	task automatic push_nibble(input logic [7:0] pattern, input logic is_last);
		push_write(pattern, 1'b0);
		push_write(pattern | enable_bits, 1'b0);
		push_write(pattern & ~enable_bits, is_last);
	endtask

	task automatic push_lcd_byte(input logic [7:0] data, input logic [7:0] sel,
			input logic is_last);
		logic [7:0] base;
		base = sel | backlight_bits;
		push_nibble(base | {data[7:4], 4'h0}, 1'b0);
		push_nibble(base | {data[3:0], 4'h0}, is_last);
	endtask

	// Expands one operation word into the expander words it should produce.
	task automatic expand_operation(input lcd_op_t op);
		logic [7:0] addr;
		case (op.command)
			CMD_INSTR: push_lcd_byte(op.value, cmd_sel_bits, 1'b1);
			CMD_CHAR:  push_lcd_byte(op.value, data_sel_bits, 1'b1);
			CMD_CURSOR: begin
				if (op.row == ROW_FIRST)
					addr = ROW1_ADDR | {4'h0, op.column[3:0]};
				else if (op.row == ROW_SECOND)
					addr = ROW2_ADDR | {4'h0, op.column[3:0]};
				else
					addr = 8'h00;
				push_lcd_byte(addr, cmd_sel_bits, 1'b1);
			end
			CMD_GLYPH: begin
				// Only eight CGRAM slots exist; higher slots produce nothing.
				if (!op.glyph_index[3])
					push_lcd_byte(CGRAM_BASE + {2'b00, op.glyph_index[2:0], 3'b000},
						cmd_sel_bits, 1'b1);
			end
			CMD_INIT: begin
				for (int k = 0; k < 6; k++)
					push_lcd_byte(POWER_UP_BYTES[(5 - k) * 8 +: 8], cmd_sel_bits, k == 5);
			end
			default: ;
		endcase
	endtask

	// Called at a rising edge; returns at the edge that accepts the word.
	task automatic send_operation(input lcd_op_t op, input row_check_t check,
			input logic [47:0] words, output int produced);
		int gap;
		int mark;
		gap = quiet ? 0 : $urandom_range(0, 3);
		repeat (gap) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		command     <= op.command;
		value       <= op.value;
		row         <= op.row;
		column      <= op.column;
		glyph_index <= op.glyph_index;
		// Inputs only move at the rising edge, so the falling edge shows
		// what the next rising edge will see.
		do @(negedge clk); while (in_stall);
		mark = writes_predicted;
		case (check)
			CHK_MODEL: expand_operation(op);
			CHK_TYPED: begin
				for (int k = 5; k >= 0; k--)
					push_write(words[k * 8 +: 8], k == 0);
			end
			default: ;
		endcase
		produced = writes_predicted - mark;
		ops_sent++;
		@(posedge clk);
	endtask

	task automatic write_register(input clcd_reg_t idx, input logic [7:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			REG_BACKLIGHT: backlight_bits = data;
			REG_ENABLE:    enable_bits    = data;
			REG_DATA_SEL:  data_sel_bits  = data;
			REG_CMD_SEL:   cmd_sel_bits   = data;
			default: ;
		endcase
	endtask

	task automatic configure_masks(input logic [7:0] bl, input logic [7:0] en,
			input logic [7:0] ds, input logic [7:0] cs);
		write_register(REG_BACKLIGHT, bl);
		write_register(REG_ENABLE, en);
		write_register(REG_DATA_SEL, ds);
		write_register(REG_CMD_SEL, cs);
		cfg_we <= 1'b0;
	endtask

	// Drops valid and waits until every expected word has come out.
	task automatic drain_writes();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_writes.size() != 0) @(posedge clk);
	endtask

	function automatic lcd_op_t random_operation();
		lcd_op_t op;
		int pick;
		op.value       = 8'($urandom);
		op.row         = 2'($urandom_range(0, 3));
		op.column      = 8'($urandom);
		op.glyph_index = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(8, 15))
			: 4'($urandom_range(0, 7));
		pick = $urandom_range(0, 99);
		if (pick < 28)
			op.command = CMD_INSTR;
		else if (pick < 55)
			op.command = CMD_CHAR;
		else if (pick < 72)
			op.command = CMD_CURSOR;
		else if (pick < 88)
			op.command = CMD_GLYPH;
		else if (pick < 94)
			op.command = CMD_INIT;
		else begin
			case ($urandom_range(0, 2))
				0: op.command = CMD_SPARE_A;
				1: op.command = CMD_SPARE_B;
				default: op.command = CMD_SPARE_C;
			endcase
		end
		return op;
	endfunction

	// Output side. Each word may wait out a random stall, drawn when the
	// previous word is taken. A long hold, requested by the sender, stalls
	// the output so the block backs up into its input.
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
				long_hold_req = 1'b0;
				out_stall <= 1'b0;
			end else if (rx_wait > 0) begin
				out_stall <= 1'b1;
				rx_wait--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Every taken word is matched against the oldest expected word.
	always @(negedge clk) begin : check_writes
		lcd_write_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_writes.size() == 0) begin
				report_mismatch($sformatf("unexpected expander word %02h last %b",
					expander_byte, last));
			end else begin
				want = pending_writes.pop_front();
				if (expander_byte !== want.expander_byte)
					report_mismatch($sformatf("expander_byte %02h, expected %02h",
						expander_byte, want.expander_byte));
				if (last !== want.last)
					report_mismatch($sformatf("last %b on word %02h, expected %b",
						last, expander_byte, want.last));
			end
			words_checked++;
			rx_wait = quiet ? 0 : $urandom_range(0, 3);
		end
	end

	initial begin : stimulus
		int produced;
		int made;
		int sent_in_phase;
		in_valid    <= 1'b0;
		command     <= CMD_INSTR;
		value       <= 8'h00;
		row         <= 2'd0;
		column      <= 8'h00;
		glyph_index <= 4'h0;
		cfg_we      <= 1'b0;
		cfg_index   <= REG_BACKLIGHT;
		cfg_data    <= 8'h00;
		backlight_bits = RST_BACKLIGHT;
		enable_bits    = RST_ENABLE;
		data_sel_bits  = RST_DATA_SEL;
		cmd_sel_bits   = RST_CMD_SEL;

		wait (arst_n === 1'b1);
		@(posedge clk);

		// Directed words run against the reset mask values.
		for (int i = 0; i < N_DIRECTED; i++)
			send_operation(directed_ops[i].op, directed_ops[i].check,
				directed_ops[i].words, produced);

		// Each phase has its own mask setting: reset values, all clear,
		// all set, overlapping enable and select bits, then two random ones.
		for (int phase = 0; phase < PHASES; phase++) begin
			if (phase > 0) begin
				drain_writes();
				repeat (SETTLE_CYCLES) @(posedge clk);
				case (phase)
					1: configure_masks(8'h00, 8'h00, 8'h00, 8'h00);
					2: configure_masks(8'hFF, 8'hFF, 8'hFF, 8'hFF);
					3: configure_masks(8'h0C, 8'h0C, 8'h05, 8'h06);
					default: configure_masks(8'($urandom), 8'($urandom),
						8'($urandom), 8'($urandom));
				endcase
			end
			// One phase runs with no gaps on either side.
			quiet = (phase == 4);
			made = 0;
			sent_in_phase = 0;
			while (made < OPS_PER_PHASE) begin
				if (phase == 2 && sent_in_phase == 6)
					long_hold_req = 1'b1;
				if (phase == 3 && sent_in_phase == 20)
					drain_writes();
				send_operation(random_operation(), CHK_MODEL, 48'h0, produced);
				if (produced > 0)
					made++;
				sent_in_phase++;
			end
		end

		drain_writes();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Covered %0d operation words over %0d mask settings, %0d expander words",
			ops_sent, PHASES, words_checked);
		$display("checked, with one long output hold and one full drain mid-phase.");
		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
